// File: rtl/core/spa_pkg.sv
// Shared types and constants of the sparse polynomial adder.
package spa_pkg;

  // Action codes of an input request
  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_ADD    = 2'd2;

  localparam int MAX_TERMS_DEF = 16;
  // Results per add are capped at this many terms
  localparam int OUT_LIMIT     = 32;
  localparam int RES_AW        = $clog2(OUT_LIMIT);
  localparam int RES_CW        = $clog2(OUT_LIMIT + 1);

  typedef struct packed {
    logic signed [15:0] coef;
    logic signed [15:0] pw;
  } term_t;

  typedef struct packed {
    logic signed [16:0] coef;
    logic signed [15:0] pw;
  } res_t;

  // Controls from the sequencer to both term stores
  typedef struct packed {
    logic sort_start;
    logic clear;
  } store_ctl_t;

endpackage

// File: rtl/core/spa_in_if.sv
// Input channel: action and term of one request.
interface spa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [15:0] coefficient;
  logic signed [15:0] power;

  modport source (output valid, action, coefficient, power, input ready);
  modport sink   (input valid, action, coefficient, power, output ready);
endinterface

// File: rtl/core/spa_out_if.sv
// Result channel: one term of the sum polynomial per request.
interface spa_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] sum_coefficient;
  logic signed [15:0] sum_power;
  logic               last;
  logic               empty_res;
  logic               dropped;

  modport source (output valid, sum_coefficient, sum_power, last, empty_res, dropped,
                  input ready);
  modport sink   (input valid, sum_coefficient, sum_power, last, empty_res, dropped,
                  output ready);
endinterface

// File: rtl/core/spa_store.sv
// Term store: memory of terms, fill count and in-place stable insertion sort.
module spa_store import spa_pkg::*; #(
  parameter int  MAX_TERMS = MAX_TERMS_DEF,
  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int CW = $clog2(MAX_TERMS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_en,
  input  term_t         load_term,
  input  store_ctl_t    ctl,
  output logic          sort_done,
  input  logic [IW-1:0] rd_addr,
  output term_t         rd_data,
  output logic [CW-1:0] count,
  output logic          full
);

  typedef enum logic [2:0] {SS_IDLE, SS_NEXT, SS_KEY, SS_CMP, SS_PUT, SS_DONE} sst_t;

  term_t         mem [MAX_TERMS];
  term_t         rd_q_r;
  sst_t          state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] i_r;
  logic [IW-1:0] j_r;
  term_t         key_r;

  logic [IW-1:0] rd_sel;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  term_t         wr_data;
  logic          shift_down;

  assign full      = (count_r == CW'(MAX_TERMS));
  assign count     = count_r;
  assign rd_data   = rd_q_r;
  assign sort_done = (state_r == SS_DONE);
  assign shift_down = ($signed(rd_q_r.pw) < $signed(key_r.pw));

  // Memory port selection: load, sort steps or external read
  always_comb begin
    rd_sel  = rd_addr;
    wr_en   = 1'b0;
    wr_addr = count_r[IW-1:0];
    wr_data = load_term;
    case (state_r)
      SS_IDLE: begin
        wr_en = load_en && !full;
      end
      SS_NEXT: rd_sel = i_r[IW-1:0];
      SS_KEY:  rd_sel = i_r[IW-1:0] - IW'(1);
      SS_CMP: begin
        if (shift_down) begin
          wr_en   = 1'b1;
          wr_addr = j_r;
          wr_data = rd_q_r;
          rd_sel  = j_r - IW'(2);
        end
      end
      SS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = key_r;
      end
      default: ;
    endcase
  end

  // Synchronous memory with registered read data
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q_r <= mem[rd_sel];
  end

  // Sort sequencer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
      count_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      case (state_r)
        SS_IDLE: begin
          if (load_en && !full) count_r <= count_r + CW'(1);
          if (ctl.sort_start) begin
            i_r     <= CW'(1);
            state_r <= SS_NEXT;
          end
        end
        SS_NEXT: begin
          if (i_r >= count_r) state_r <= SS_DONE;
          else                state_r <= SS_KEY;
        end
        SS_KEY: begin
          key_r   <= rd_q_r;
          j_r     <= i_r[IW-1:0];
          state_r <= SS_CMP;
        end
        SS_CMP: begin
          if (shift_down) begin
            j_r <= j_r - IW'(1);
            if (j_r == IW'(1)) state_r <= SS_PUT;
          end else begin
            state_r <= SS_PUT;
          end
        end
        SS_PUT: begin
          i_r     <= i_r + CW'(1);
          state_r <= SS_NEXT;
        end
        SS_DONE: begin
          if (ctl.clear) begin
            count_r <= '0;
            state_r <= SS_IDLE;
          end
        end
        default: state_r <= SS_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TERMS))
    else $error("term count above capacity");
  a_sort_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r != SS_IDLE) |-> (CW'(wr_addr) < count_r))
    else $error("sort wrote beyond filled entries");
  a_no_load_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != SS_IDLE) |=> (count_r == $past(count_r) || count_r == '0))
    else $error("count changed during sort");

endmodule

// File: rtl/core/spa_merge.sv
// Add sequencer: starts the sorts, merges both stores into a result memory, emits.
module spa_merge import spa_pkg::*; #(
  parameter int  MAX_TERMS = MAX_TERMS_DEF,
  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int CW = $clog2(MAX_TERMS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          ovf,
  input  logic [CW-1:0] count_a,
  input  logic [CW-1:0] count_b,
  input  logic          done_a,
  input  logic          done_b,
  output logic [IW-1:0] rd_a_addr,
  output logic [IW-1:0] rd_b_addr,
  input  term_t         qa,
  input  term_t         qb,
  output store_ctl_t    ctl,
  output logic          busy,
  spa_out_if.source     out_ch
);

  typedef enum logic [2:0] {M_IDLE, M_SORT, M_RD, M_EVAL, M_ERD, M_ESHOW, M_EWAIT} mst_t;

  res_t              res_mem [OUT_LIMIT];
  res_t              res_q_r;
  mst_t              state_r;
  logic [CW-1:0]     a_r, b_r;
  logic [RES_CW-1:0] rc_r, k_r;
  logic              trunc_r;
  logic              valid_r, last_r, empty_r, drop_r;
  logic signed [16:0] coef_r;
  logic signed [15:0] pw_r;

  logic               a_has, b_has;
  logic               prod, adv_a, adv_b, fin;
  res_t               prod_term;
  logic signed [16:0] csum;

  assign rd_a_addr = a_r[IW-1:0];
  assign rd_b_addr = b_r[IW-1:0];
  assign a_has     = (a_r < count_a);
  assign b_has     = (b_r < count_b);
  assign csum      = 17'(qa.coef) + 17'(qb.coef);
  assign busy      = (state_r != M_IDLE);

  assign ctl.sort_start = (state_r == M_IDLE) && start;
  assign ctl.clear      = (state_r == M_EWAIT) && out_ch.ready && last_r;

  assign out_ch.valid           = valid_r;
  assign out_ch.sum_coefficient = coef_r;
  assign out_ch.sum_power       = pw_r;
  assign out_ch.last            = last_r;
  assign out_ch.empty_res       = empty_r;
  assign out_ch.dropped         = drop_r;

  // One merge step on the two heads
  always_comb begin
    prod      = 1'b0;
    adv_a     = 1'b0;
    adv_b     = 1'b0;
    fin       = 1'b0;
    prod_term = '{coef: 17'(qa.coef), pw: qa.pw};
    if (a_has && b_has) begin
      if (qa.pw == qb.pw) begin
        prod      = (csum != 17'sd0);
        prod_term = '{coef: csum, pw: qa.pw};
        adv_a     = 1'b1;
        adv_b     = 1'b1;
      end else if ($signed(qa.pw) > $signed(qb.pw)) begin
        prod  = 1'b1;
        adv_a = 1'b1;
      end else begin
        prod      = 1'b1;
        prod_term = '{coef: 17'(qb.coef), pw: qb.pw};
        adv_b     = 1'b1;
      end
    end else if (a_has) begin
      prod  = 1'b1;
      adv_a = 1'b1;
    end else if (b_has) begin
      prod      = 1'b1;
      prod_term = '{coef: 17'(qb.coef), pw: qb.pw};
      adv_b     = 1'b1;
    end else begin
      fin = 1'b1;
    end
  end

  // Result memory
  always_ff @(posedge clk) begin
    if (state_r == M_EVAL && prod && rc_r != RES_CW'(OUT_LIMIT))
      res_mem[rc_r[RES_AW-1:0]] <= prod_term;
    res_q_r <= res_mem[k_r[RES_AW-1:0]];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      valid_r <= 1'b0;
      a_r     <= '0;
      b_r     <= '0;
      rc_r    <= '0;
      k_r     <= '0;
      trunc_r <= 1'b0;
    end else begin
      case (state_r)
        M_IDLE: begin
          if (start) begin
            a_r     <= '0;
            b_r     <= '0;
            rc_r    <= '0;
            k_r     <= '0;
            trunc_r <= 1'b0;
            state_r <= M_SORT;
          end
        end
        M_SORT: if (done_a && done_b) state_r <= M_RD;
        M_RD:   state_r <= M_EVAL;
        M_EVAL: begin
          if (adv_a) a_r <= a_r + CW'(1);
          if (adv_b) b_r <= b_r + CW'(1);
          if (prod) begin
            if (rc_r == RES_CW'(OUT_LIMIT)) trunc_r <= 1'b1;
            else                            rc_r    <= rc_r + RES_CW'(1);
          end
          if (fin) begin
            if (rc_r == '0) begin
              // empty sum: single flagged request
              coef_r  <= '0;
              pw_r    <= '0;
              last_r  <= 1'b1;
              empty_r <= 1'b1;
              drop_r  <= ovf || trunc_r;
              valid_r <= 1'b1;
              state_r <= M_EWAIT;
            end else begin
              state_r <= M_ERD;
            end
          end else begin
            state_r <= M_RD;
          end
        end
        M_ERD: state_r <= M_ESHOW;
        M_ESHOW: begin
          coef_r  <= res_q_r.coef;
          pw_r    <= res_q_r.pw;
          last_r  <= (k_r == rc_r - RES_CW'(1));
          empty_r <= 1'b0;
          drop_r  <= ovf || trunc_r;
          valid_r <= 1'b1;
          state_r <= M_EWAIT;
        end
        M_EWAIT: begin
          if (out_ch.ready) begin
            valid_r <= 1'b0;
            if (last_r) begin
              state_r <= M_IDLE;
            end else begin
              k_r     <= k_r + RES_CW'(1);
              state_r <= M_ERD;
            end
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  a_valid_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (state_r == M_EWAIT))
    else $error("result shown outside emit wait");
  a_rc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= RES_CW'(OUT_LIMIT))
    else $error("result count above limit");
  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (state_r == M_IDLE && !valid_r))
    else $error("add did not finish after last result");
  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == M_ESHOW) |-> (k_r < rc_r))
    else $error("emit index past result count");

endmodule

// File: rtl/core/sparse_polynomial_adder.sv
// Sparse polynomial adder: loads terms of two polynomials, sorts, merges and emits the sum.
//
// Input channel in_ch: action 0 loads (coefficient, power) into the first store,
// action 1 into the second, action 2 adds; action 3 is taken and ignored.
// Loads are taken one per cycle while no add is in progress. A term for a full
// store is discarded and the overflow flag set, reported as dropped on every result
// of the next add. An add holds in_ch.ready low until its last result is taken.
// Each store is sorted by descending power with a stable insertion sort in its
// memory, both stores in parallel, then the merge walks both stores into a
// 32-entry result memory. Results go out through an output register; when
// out_ch.ready is low the result holds and the block waits. The final result
// carries last; an empty sum gives one result flagged empty_res.
// After the last result both stores and the overflow flag are cleared.
// Synchronous active-low reset empties the stores; no clearing pass is needed.
module sparse_polynomial_adder import spa_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  spa_in_if.sink   in_ch,
  spa_out_if.source out_ch
);

  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);

  store_ctl_t    ctl;
  logic          busy, acc;
  logic          load_a, load_b, start;
  logic          full_a, full_b, done_a, done_b;
  logic [CW-1:0] count_a, count_b;
  logic [IW-1:0] rd_a_addr, rd_b_addr;
  term_t         qa, qb, in_term;
  logic          ovf_r;

  assign in_ch.ready = !busy;
  assign acc     = in_ch.valid && !busy;
  assign load_a  = acc && (in_ch.action == ACT_LOAD_A);
  assign load_b  = acc && (in_ch.action == ACT_LOAD_B);
  assign start   = acc && (in_ch.action == ACT_ADD);
  assign in_term = '{coef: in_ch.coefficient, pw: in_ch.power};

  // Overflow flag: set by a load into a full store, cleared after an add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else if (ctl.clear) begin
      ovf_r <= 1'b0;
    end else if ((load_a && full_a) || (load_b && full_b)) begin
      ovf_r <= 1'b1;
    end
  end

  spa_store #(.MAX_TERMS(MAX_TERMS)) u_store_a (
    .clk, .rst_n, .load_en(load_a), .load_term(in_term), .ctl,
    .sort_done(done_a), .rd_addr(rd_a_addr), .rd_data(qa),
    .count(count_a), .full(full_a)
  );

  spa_store #(.MAX_TERMS(MAX_TERMS)) u_store_b (
    .clk, .rst_n, .load_en(load_b), .load_term(in_term), .ctl,
    .sort_done(done_b), .rd_addr(rd_b_addr), .rd_data(qb),
    .count(count_b), .full(full_b)
  );

  spa_merge #(.MAX_TERMS(MAX_TERMS)) u_merge (
    .clk, .rst_n, .start, .ovf(ovf_r),
    .count_a, .count_b, .done_a, .done_b,
    .rd_a_addr, .rd_b_addr, .qa, .qb,
    .ctl, .busy, .out_ch
  );

endmodule
